FILE: rtl/gspc_pkg.sv
// Package for the gas sensor ppm conditioner: field widths, constants,
// register indexes, datapath command codes and the controller status bundle.
// No dependencies.
package gspc_pkg;

   localparam int ADC_BITS       = 12;
   localparam int ADC_W          = 12;
   localparam int COUNT_BITS_DEF = 16;
   localparam int RL_W           = 20;
   localparam int MV_W           = 13;
   localparam int PPM_W          = 14;
   localparam int LVL_W          = 3;
   localparam int REF_W          = 32;
   localparam int SUM_W          = 32;
   localparam int CSR_IDX_W      = 2;
   localparam int CSR_DATA_W     = 20;
   localparam int REQ_DATA_W     = 16;
   localparam int RSP_DATA_W     = 64;
   localparam int RSP_USER_W     = 2;

   localparam int DIV_NUM_W      = 64;
   localparam int DIV_DEN_W      = 40;
   localparam int SQ_RAD_W       = 40;
   localparam int SQ_ROOT_W      = 20;
   localparam int X_W            = 21;
   localparam int X2_W           = 26;
   localparam int X3_W           = 31;
   localparam int P_W            = 35;

   localparam logic [ADC_W-1:0] ADC_MASK = ADC_W'((64'd1 << ADC_BITS) - 64'd1);
   localparam logic [DIV_DEN_W-1:0] ADC_FULL = DIV_DEN_W'((64'd1 << ADC_BITS) - 64'd1);

   localparam logic [MV_W-1:0]  MV_SCALE  = 13'd4950;
   localparam logic [MV_W-1:0]  MV_MAX    = 13'd5000;
   localparam logic [PPM_W-1:0] PPM_MAX   = 14'd10000;
   localparam logic [DIV_NUM_W-1:0] X_LIMIT = 64'd20 << 16;

   localparam logic [RL_W-1:0]  RL_RESET  = 20'd10000;
   localparam logic [MV_W-1:0]  VC_RESET  = 13'd5000;
   localparam logic [MV_W-1:0]  THR_RESET = 13'd3000;

   localparam logic [MV_W-1:0]  LVL_T1 = 13'd500;
   localparam logic [MV_W-1:0]  LVL_T2 = 13'd1500;
   localparam logic [MV_W-1:0]  LVL_T3 = 13'd2500;
   localparam logic [MV_W-1:0]  LVL_T4 = 13'd3500;

   localparam logic [CSR_IDX_W-1:0] CSR_LOAD_RES = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SUPPLY   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ALARM    = 2'd2;

   typedef enum logic [LVL_W-1:0] {
      LEVEL_NORMAL   = 3'd0,
      LEVEL_LOW      = 3'd1,
      LEVEL_MEDIUM   = 3'd2,
      LEVEL_HIGH     = 3'd3,
      LEVEL_CRITICAL = 3'd4
   } level_type;

   typedef enum logic [4:0] {
      OP_NONE,
      OP_LOAD,
      OP_MV_MUL,
      OP_DIV_GO,
      OP_MV_FIN,
      OP_CAL_ACC,
      OP_REF_TOP,
      OP_REF_SPEC,
      OP_REF_DIFF,
      OP_REF_NUM,
      OP_REF_SCALE,
      OP_REF_RND,
      OP_REF_FIN,
      OP_PPM_N1,
      OP_PPM_N2,
      OP_PPM_D1,
      OP_PPM_D2,
      OP_PPM_MAX,
      OP_X_LOAD,
      OP_X2,
      OP_X3,
      OP_SQ_X,
      OP_SQ_R,
      OP_PPM_P,
      OP_PPM_FIN,
      OP_OUT
   } dp_op_type;

   typedef struct packed {
      logic mode;
      logic last;
      logic div_done;
      logic sq_done;
      logic ref_special;
      logic ppm_skip;
      logic x_big;
   } dp_status_type;

endpackage

FILE: rtl/gspc_divider.sv
// Restoring bit-serial divider, one quotient bit per cycle.
// Depends on gspc_pkg for operand widths.
module gspc_divider (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [gspc_pkg::DIV_NUM_W-1:0] num,
   input  logic [gspc_pkg::DIV_DEN_W-1:0] den,
   output logic [gspc_pkg::DIV_NUM_W-1:0] quo,
   output logic                           done
);
   import gspc_pkg::*;

   localparam int CNT_W = $clog2(DIV_NUM_W);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic [DIV_DEN_W-1:0] rem_ff, rem_in;
   logic [DIV_DEN_W-1:0] den_ff, den_in;
   logic [DIV_NUM_W-1:0] quo_ff, quo_in;
   logic [DIV_DEN_W:0]   trial;
   logic                 fits;

   always_comb begin
      trial   = {rem_ff, quo_ff[DIV_NUM_W-1]};
      fits    = trial >= {1'b0, den_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      quo_in  = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         den_in  = den;
         quo_in  = num;
      end else if (busy_ff) begin
         rem_in = fits ? DIV_DEN_W'(trial - {1'b0, den_ff}) : trial[DIV_DEN_W-1:0];
         quo_in = {quo_ff[DIV_NUM_W-2:0], fits};
         cnt_in = cnt_ff + 1'b1;
         if (&cnt_ff) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      den_ff <= den_in;
      quo_ff <= quo_in;
   end

   assign quo  = quo_ff;
   assign done = done_ff;

endmodule

FILE: rtl/gspc_sqrt.sv
// Iterative floor square root, one result bit per cycle.
// Depends on gspc_pkg for radicand and root widths.
module gspc_sqrt (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [gspc_pkg::SQ_RAD_W-1:0] rad,
   output logic [gspc_pkg::SQ_ROOT_W-1:0] root,
   output logic                          done
);
   import gspc_pkg::*;

   localparam int CNT_W = $clog2(SQ_RAD_W / 2);
   localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(SQ_RAD_W / 2 - 1);

   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic [SQ_RAD_W-1:0] v_ff, v_in;
   logic [SQ_RAD_W-1:0] res_ff, res_in;
   logic [SQ_RAD_W-1:0] bit_ff, bit_in;
   logic [SQ_RAD_W-1:0] trial;

   always_comb begin
      trial   = res_ff + bit_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      v_in    = v_ff;
      res_in  = res_ff;
      bit_in  = bit_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         v_in    = rad;
         res_in  = '0;
         bit_in  = SQ_RAD_W'(1) << (SQ_RAD_W - 2);
      end else if (busy_ff) begin
         if (v_ff >= trial) begin
            v_in   = v_ff - trial;
            res_in = (res_ff >> 1) + bit_ff;
         end else begin
            res_in = res_ff >> 1;
         end
         bit_in = bit_ff >> 2;
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == LAST_STEP) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      v_ff   <= v_in;
      res_ff <= res_in;
      bit_ff <= bit_in;
   end

   assign root = res_ff[SQ_ROOT_W-1:0];
   assign done = done_ff;

endmodule

FILE: rtl/gspc_datapath.sv
// Datapath: config registers, calibration state, one multiplier step per
// command, shared divider and square root, and the result register.
// Depends on gspc_pkg, gspc_divider and gspc_sqrt.
module gspc_datapath #(
   parameter int COUNT_BITS = gspc_pkg::COUNT_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  gspc_pkg::dp_op_type             op,
   output gspc_pkg::dp_status_type         status,
   input  logic                            in_mode,
   input  logic [gspc_pkg::ADC_W-1:0]      in_code,
   input  logic                            in_last,
   input  logic                            csr_we,
   input  logic [gspc_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [gspc_pkg::CSR_DATA_W-1:0] csr_wdata,
   output logic [gspc_pkg::MV_W-1:0]       out_mv,
   output logic [gspc_pkg::PPM_W-1:0]      out_ppm,
   output logic                            out_alarm,
   output logic [gspc_pkg::LVL_W-1:0]      out_level,
   output logic                            out_cal,
   output logic [gspc_pkg::REF_W-1:0]      out_ref
);
   import gspc_pkg::*;

   localparam logic [MV_W:0] MV_REM_1 = (MV_W+1)'(ADC_FULL);
   localparam logic [MV_W:0] MV_REM_2 = (MV_W+1)'(ADC_FULL << 1);

   logic [RL_W-1:0]       rl_ff;
   logic [MV_W-1:0]       vc_ff, thr_ff;

   logic [ADC_W-1:0]      code_ff, code_in;
   logic                  mode_ff, mode_in, last_ff, last_in;
   logic [MV_W-1:0]       mv_ff, mv_in;
   logic [SUM_W-1:0]      sum_ff, sum_in;
   logic [COUNT_BITS-1:0] cnt_ff, cnt_in;
   logic [REF_W-1:0]      ref_ff, ref_in;
   logic                  cal_ff, cal_in;
   logic [63:0]           prod_ff, prod_in;
   logic [DIV_NUM_W-1:0]  num_ff, num_in;
   logic [DIV_DEN_W-1:0]  den_ff, den_in;
   logic [31:0]           diff_ff, diff_in;
   logic [X_W-1:0]        x_ff, x_in;
   logic [X2_W-1:0]       x2_ff, x2_in;
   logic [X3_W-1:0]       x3_ff, x3_in;
   logic [P_W-1:0]        p_ff, p_in;
   logic [PPM_W-1:0]      ppm_ff, ppm_in;

   logic [MV_W-1:0]       o_mv_ff, o_mv_in;
   logic [PPM_W-1:0]      o_ppm_ff, o_ppm_in;
   logic                  o_alarm_ff, o_alarm_in;
   level_type             o_level_ff, o_level_in;
   logic                  o_cal_ff, o_cal_in;
   logic [REF_W-1:0]      o_ref_ff, o_ref_in;

   logic [24:0]               mv_prod;
   logic [MV_W-1:0]           mv_q0, mv_quo;
   logic [MV_W:0]             mv_rem;
   logic [MV_W+COUNT_BITS-1:0] top_prod;
   logic [51:0]               rl_diff;
   logic [38:0]               sum98;
   logic [44:0]               mv_ref;
   logic [32:0]               rl_vd;
   logic [2*X_W-1:0]          x2_full;
   logic [X2_W+X_W-1:0]       x3_full;
   logic [X3_W+SQ_ROOT_W-1:0] p_full;
   logic [P_W:0]              p_rnd;
   logic [SUM_W:0]            sum_add;
   logic                      top_le_s;

   logic [DIV_NUM_W-1:0]  quo;
   logic                  div_done, div_start;
   logic [SQ_RAD_W-1:0]   sq_rad;
   logic [SQ_ROOT_W-1:0]  root;
   logic                  sq_done, sq_start;

   always_ff @(posedge clock) begin
      if (reset) begin
         rl_ff  <= RL_RESET;
         vc_ff  <= VC_RESET;
         thr_ff <= THR_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_LOAD_RES: rl_ff  <= csr_wdata[RL_W-1:0];
            CSR_SUPPLY:   vc_ff  <= csr_wdata[MV_W-1:0];
            CSR_ALARM:    thr_ff <= csr_wdata[MV_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      mv_prod  = code_ff * MV_SCALE;
      // x / 4095: x >> 12, then the remainder x[11:0] + q0 needs at most two steps
      mv_q0    = prod_ff[ADC_BITS+MV_W-1:ADC_BITS];
      mv_rem   = (MV_W+1)'(prod_ff[ADC_BITS-1:0]) + {1'b0, mv_q0};
      if (mv_rem >= MV_REM_2)      mv_quo = mv_q0 + 13'd2;
      else if (mv_rem >= MV_REM_1) mv_quo = mv_q0 + 13'd1;
      else                         mv_quo = mv_q0;
      top_prod = vc_ff * cnt_ff;
      rl_diff  = rl_ff * diff_ff;
      sum98    = sum_ff * 7'd98;
      mv_ref   = mv_ff * ref_ff;
      rl_vd    = rl_ff * diff_ff[MV_W-1:0];
      x2_full  = x_ff * x_ff;
      x3_full  = x2_ff * x_ff;
      p_full   = x3_ff * root;
      p_rnd    = {1'b0, p_ff} + (P_W+1)'(32768);
      sum_add  = {1'b0, sum_ff} + (SUM_W+1)'(mv_ff);
      top_le_s = prod_ff <= {32'd0, sum_ff};
   end

   always_comb begin
      code_in    = code_ff;
      mode_in    = mode_ff;
      last_in    = last_ff;
      mv_in      = mv_ff;
      sum_in     = sum_ff;
      cnt_in     = cnt_ff;
      ref_in     = ref_ff;
      cal_in     = cal_ff;
      prod_in    = prod_ff;
      num_in     = num_ff;
      den_in     = den_ff;
      diff_in    = diff_ff;
      x_in       = x_ff;
      x2_in      = x2_ff;
      x3_in      = x3_ff;
      p_in       = p_ff;
      ppm_in     = ppm_ff;
      o_mv_in    = o_mv_ff;
      o_ppm_in   = o_ppm_ff;
      o_alarm_in = o_alarm_ff;
      o_level_in = o_level_ff;
      o_cal_in   = o_cal_ff;
      o_ref_in   = o_ref_ff;
      unique case (op)
         OP_LOAD: begin
            code_in = in_code & ADC_MASK;
            mode_in = in_mode;
            last_in = in_last;
            ppm_in  = '0;
         end
         OP_MV_MUL:  prod_in = 64'(mv_prod);
         OP_MV_FIN:  mv_in = (mv_quo > MV_MAX) ? MV_MAX : mv_quo;
         OP_CAL_ACC: begin
            if (~&cnt_ff) begin
               sum_in = sum_add[SUM_W] ? '1 : sum_add[SUM_W-1:0];
               cnt_in = cnt_ff + 1'b1;
            end
         end
         OP_REF_TOP:  prod_in = 64'(top_prod);
         OP_REF_SPEC: begin
            ref_in = top_le_s ? '0 : '1;
            cal_in = 1'b1;
            sum_in = '0;
            cnt_in = '0;
         end
         OP_REF_DIFF: diff_in = 32'(prod_ff - {32'd0, sum_ff});
         OP_REF_NUM:  prod_in = 64'(rl_diff);
         OP_REF_SCALE: begin
            num_in = (prod_ff << 3) + (prod_ff << 1);
            den_in = DIV_DEN_W'(sum98);
         end
         OP_REF_RND: num_in = num_ff + DIV_NUM_W'(den_ff >> 1);
         OP_REF_FIN: begin
            ref_in = (|quo[63:32]) ? '1 : quo[31:0];
            cal_in = 1'b1;
            sum_in = '0;
            cnt_in = '0;
         end
         OP_PPM_N1: prod_in = 64'(mv_ref);
         OP_PPM_N2: begin
            num_in  = prod_ff << 17;
            diff_in = 32'(vc_ff - mv_ff);
         end
         OP_PPM_D1:  prod_in = 64'(rl_vd);
         OP_PPM_D2:  den_in = (DIV_DEN_W'(prod_ff[32:0]) << 2) +
                              DIV_DEN_W'(prod_ff[32:0]);
         OP_PPM_MAX: ppm_in = PPM_MAX;
         OP_X_LOAD:  x_in = quo[X_W-1:0];
         OP_X2:      x2_in = x2_full[2*X_W-1:16];
         OP_X3:      x3_in = x3_full[X2_W+X_W-1:16];
         OP_PPM_P:   p_in = p_full[X3_W+SQ_ROOT_W-1:16];
         OP_PPM_FIN: ppm_in = (p_rnd[P_W:16] > (P_W-15)'(PPM_MAX)) ?
                              PPM_MAX : p_rnd[PPM_W+15:16];
         OP_OUT: begin
            o_mv_in    = mv_ff;
            o_ppm_in   = ppm_ff;
            o_alarm_in = mv_ff >= thr_ff;
            if (mv_ff < LVL_T1)      o_level_in = LEVEL_NORMAL;
            else if (mv_ff < LVL_T2) o_level_in = LEVEL_LOW;
            else if (mv_ff < LVL_T3) o_level_in = LEVEL_MEDIUM;
            else if (mv_ff < LVL_T4) o_level_in = LEVEL_HIGH;
            else                     o_level_in = LEVEL_CRITICAL;
            o_cal_in   = cal_ff;
            o_ref_in   = ref_ff;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff <= '0;
         cnt_ff <= '0;
         ref_ff <= '0;
         cal_ff <= 1'b0;
      end else begin
         sum_ff <= sum_in;
         cnt_ff <= cnt_in;
         ref_ff <= ref_in;
         cal_ff <= cal_in;
      end
      code_ff    <= code_in;
      mode_ff    <= mode_in;
      last_ff    <= last_in;
      mv_ff      <= mv_in;
      prod_ff    <= prod_in;
      num_ff     <= num_in;
      den_ff     <= den_in;
      diff_ff    <= diff_in;
      x_ff       <= x_in;
      x2_ff      <= x2_in;
      x3_ff      <= x3_in;
      p_ff       <= p_in;
      ppm_ff     <= ppm_in;
      o_mv_ff    <= o_mv_in;
      o_ppm_ff   <= o_ppm_in;
      o_alarm_ff <= o_alarm_in;
      o_level_ff <= o_level_in;
      o_cal_ff   <= o_cal_in;
      o_ref_ff   <= o_ref_in;
   end

   assign div_start = op == OP_DIV_GO;
   assign sq_start  = (op == OP_SQ_X) || (op == OP_SQ_R);
   assign sq_rad    = (op == OP_SQ_X) ? {3'd0, x_ff, 16'd0} : {4'd0, root, 16'd0};

   gspc_divider u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (num_ff),
      .den   (den_ff),
      .quo   (quo),
      .done  (div_done)
   );

   gspc_sqrt u_sqrt (
      .clock (clock),
      .reset (reset),
      .start (sq_start),
      .rad   (sq_rad),
      .root  (root),
      .done  (sq_done)
   );

   always_comb begin
      status.mode        = mode_ff;
      status.last        = last_ff;
      status.div_done    = div_done;
      status.sq_done     = sq_done;
      status.ref_special = top_le_s || (sum_ff == '0);
      status.ppm_skip    = !cal_ff || (ref_ff == '0) || (mv_ff <= 13'd1) ||
                           (vc_ff <= mv_ff) || (rl_ff == '0);
      status.x_big       = quo > X_LIMIT;
   end

   assign out_mv    = o_mv_ff;
   assign out_ppm   = o_ppm_ff;
   assign out_alarm = o_alarm_ff;
   assign out_level = o_level_ff;
   assign out_cal   = o_cal_ff;
   assign out_ref   = o_ref_ff;

endmodule

FILE: rtl/gspc_ctrl.sv
// Controller: sequences datapath commands for one item and runs both
// stream handshakes. Depends on gspc_pkg.
module gspc_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   input  gspc_pkg::dp_status_type status,
   output gspc_pkg::dp_op_type     op
);
   import gspc_pkg::*;

   typedef enum logic [4:0] {
      S_IDLE, S_MV_MUL, S_MV_FIN, S_BRANCH, S_CAL_ACC,
      S_REF_TOP, S_REF_CHK, S_REF_NUM, S_REF_SCALE, S_REF_RND, S_REF_GO,
      S_REF_WAIT, S_REF_FIN, S_PPM_N2, S_PPM_D1, S_PPM_D2, S_PPM_GO,
      S_PPM_WAIT, S_PPM_X, S_X2, S_X3, S_SQ_GO, S_SQ_WAIT, S_PPM_P,
      S_PPM_FIN, S_DONE
   } state_type;

   state_type  state_ff, state_in;
   logic       valid_ff, valid_in;
   logic [1:0] sq_cnt_ff, sq_cnt_in;
   logic       out_free;

   assign out_free = !valid_ff || rsp_tready;

   always_comb begin
      state_in  = state_ff;
      sq_cnt_in = sq_cnt_ff;
      valid_in  = valid_ff && !rsp_tready;
      op        = OP_NONE;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               op       = OP_LOAD;
               state_in = S_MV_MUL;
            end
         end
         S_MV_MUL: begin
            op       = OP_MV_MUL;
            state_in = S_MV_FIN;
         end
         S_MV_FIN: begin
            op       = OP_MV_FIN;
            state_in = S_BRANCH;
         end
         S_BRANCH: begin
            if (status.mode) begin
               state_in = S_CAL_ACC;
            end else if (status.ppm_skip) begin
               state_in = S_DONE;
            end else begin
               op       = OP_PPM_N1;
               state_in = S_PPM_N2;
            end
         end
         S_CAL_ACC: begin
            op       = OP_CAL_ACC;
            state_in = status.last ? S_REF_TOP : S_DONE;
         end
         S_REF_TOP: begin
            op       = OP_REF_TOP;
            state_in = S_REF_CHK;
         end
         S_REF_CHK: begin
            if (status.ref_special) begin
               op       = OP_REF_SPEC;
               state_in = S_DONE;
            end else begin
               op       = OP_REF_DIFF;
               state_in = S_REF_NUM;
            end
         end
         S_REF_NUM: begin
            op       = OP_REF_NUM;
            state_in = S_REF_SCALE;
         end
         S_REF_SCALE: begin
            op       = OP_REF_SCALE;
            state_in = S_REF_RND;
         end
         S_REF_RND: begin
            op       = OP_REF_RND;
            state_in = S_REF_GO;
         end
         S_REF_GO: begin
            op       = OP_DIV_GO;
            state_in = S_REF_WAIT;
         end
         S_REF_WAIT: if (status.div_done) state_in = S_REF_FIN;
         S_REF_FIN: begin
            op       = OP_REF_FIN;
            state_in = S_DONE;
         end
         S_PPM_N2: begin
            op       = OP_PPM_N2;
            state_in = S_PPM_D1;
         end
         S_PPM_D1: begin
            op       = OP_PPM_D1;
            state_in = S_PPM_D2;
         end
         S_PPM_D2: begin
            op       = OP_PPM_D2;
            state_in = S_PPM_GO;
         end
         S_PPM_GO: begin
            op       = OP_DIV_GO;
            state_in = S_PPM_WAIT;
         end
         S_PPM_WAIT: if (status.div_done) state_in = S_PPM_X;
         S_PPM_X: begin
            if (status.x_big) begin
               op       = OP_PPM_MAX;
               state_in = S_DONE;
            end else begin
               op       = OP_X_LOAD;
               state_in = S_X2;
            end
         end
         S_X2: begin
            op       = OP_X2;
            state_in = S_X3;
         end
         S_X3: begin
            op        = OP_X3;
            sq_cnt_in = '0;
            state_in  = S_SQ_GO;
         end
         S_SQ_GO: begin
            op       = (sq_cnt_ff == 2'd0) ? OP_SQ_X : OP_SQ_R;
            state_in = S_SQ_WAIT;
         end
         S_SQ_WAIT: begin
            if (status.sq_done) begin
               sq_cnt_in = sq_cnt_ff + 1'b1;
               state_in  = (sq_cnt_ff == 2'd2) ? S_PPM_P : S_SQ_GO;
            end
         end
         S_PPM_P: begin
            op       = OP_PPM_P;
            state_in = S_PPM_FIN;
         end
         S_PPM_FIN: begin
            op       = OP_PPM_FIN;
            state_in = S_DONE;
         end
         S_DONE: begin
            if (out_free) begin
               op       = OP_OUT;
               valid_in = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         valid_ff  <= 1'b0;
         sq_cnt_ff <= '0;
      end else begin
         state_ff  <= state_in;
         valid_ff  <= valid_in;
         sq_cnt_ff <= sq_cnt_in;
      end
   end

   assign req_tready = state_ff == S_IDLE;
   assign rsp_tvalid = valid_ff;

endmodule

FILE: rtl/gas_sensor_ppm_conditioner.sv
// Top level of the gas sensor ppm conditioner: controller plus datapath.
// Depends on gspc_pkg, gspc_ctrl and gspc_datapath.
//
// One 12-bit converter code per transfer becomes sensor millivolts, a ppm
// figure from the power-law gas curve, alarm, level, calibrated flag and the
// stored clean-air reference. Items are handled one at a time; the result
// sits in an output register so the next transfer is taken while it waits.
// Paths per transfer: a calibration sample, a measure sample with the ppm
// forced to zero, a final calibration sample whose reference takes a special
// value or comes from the 64-step divider, a measure sample whose ppm
// saturates after the divide, and a full measure sample (a divide plus three
// 20-step square roots). A result still waiting on the output holds the block
// in its last state until it is taken.
module gas_sensor_ppm_conditioner #(
   parameter int COUNT_BITS = gspc_pkg::COUNT_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [gspc_pkg::REQ_DATA_W-1:0] req_tdata,  // adc_code
   input  logic                            req_tlast,  // last_sample
   input  logic                            req_tuser,  // mode
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // sensor_mv, gas_ppm, level, reference_ohms, zero pad
   output logic [gspc_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output logic [gspc_pkg::RSP_USER_W-1:0] rsp_tuser,  // alarm, is_calibrated
   input  logic                            csr_we,
   input  logic [gspc_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [gspc_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import gspc_pkg::*;

   dp_op_type       op;
   dp_status_type   status;
   logic [MV_W-1:0]  out_mv;
   logic [PPM_W-1:0] out_ppm;
   logic             out_alarm;
   logic [LVL_W-1:0] out_level;
   logic             out_cal;
   logic [REF_W-1:0] out_ref;

   gspc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .op         (op)
   );

   gspc_datapath #(
      .COUNT_BITS (COUNT_BITS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .op        (op),
      .status    (status),
      .in_mode   (req_tuser),
      .in_code   (req_tdata[ADC_W-1:0]),
      .in_last   (req_tlast),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .out_mv    (out_mv),
      .out_ppm   (out_ppm),
      .out_alarm (out_alarm),
      .out_level (out_level),
      .out_cal   (out_cal),
      .out_ref   (out_ref)
   );

   assign rsp_tdata = {2'd0, out_ref, out_level, out_ppm, out_mv};
   assign rsp_tuser = {out_cal, out_alarm};

endmodule
